FILE: rtl/core/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants for the jump search table block.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int CNT_W               = 11;  // entry count, 0..2047
  localparam int IDX_W               = 10;  // write index field
  localparam int DATA_W              = 32;  // table word
  localparam int POS_W               = 11;  // signed result index
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // floor square root of an 11-bit count fits in 6 bits; two radicand bits a step
  localparam int SQRT_W     = 6;
  localparam int RAD_W      = 2 * SQRT_W;
  localparam int REM_W      = SQRT_W + 2;
  localparam int SQRT_STEPS = SQRT_W;
  localparam int STEP_W     = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef logic [CNT_W-1:0] cfg_word_t;

  typedef struct packed {
    op_t                      opcode;
    logic [IDX_W-1:0]         write_index;
    logic signed [DATA_W-1:0] item_value;
  } req_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] match_position;
  } rsp_item_t;

  localparam logic [POS_W-1:0] POS_NONE = '1;

endpackage

FILE: rtl/core/jss_chan_if.sv
// ----------------------------------------------------------------------------
// jss_chan_if
// Valid/ready channel carrying one payload item of type T.
// ----------------------------------------------------------------------------
interface jss_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

FILE: rtl/core/jump_search_sorted_table.sv
// ----------------------------------------------------------------------------
// jump_search_sorted_table
// Sorted table of signed 32-bit words with a jump search over the first
// entries_in_use entries. Write items fill the table; search items return
// the index of the first equal entry in the scanned block, or -1.
// ----------------------------------------------------------------------------
// Operation: a write item gives no result. A search makes P table reads,
//   P being about ceil(n/jump) + jump, so near 64 for n = 1024, at one read
//   per cycle on the single table read port, then loads the result into
//   the output register.
// Throughput: one item at a time; the next item is taken once the result
//   has moved into the output register.
// A configuration write holds off items while the jump step (floor square
//   root of the capped count) is worked out, two bits a cycle.
// Reset: clears the count and the jump step, drops any pending result.
//   Table contents stay undefined until written.
// ----------------------------------------------------------------------------
module jump_search_sorted_table #(
  parameter int TABLE_DEPTH = jss_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  jss_chan_if.sink    cfg,
  jss_chan_if.sink    req,
  jss_chan_if.source  rsp
);

  import jss_pkg::*;

  // Only IDX_W bits of index can ever be written, so the store never needs
  // more than 2**IDX_W words even for a deeper table setting.
  localparam int MEM_DEPTH = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
  localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQRT = 5'b00010,
    S_JUMP = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // Clamp a count to the table depth.
  function automatic logic [CNT_W-1:0] cap_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (int'(v) > TABLE_DEPTH) begin
      r = CNT_W'(TABLE_DEPTH);
    end
    return r;
  endfunction

  state_t                   state;
  logic [CNT_W-1:0]         entries_in_use;
  logic [SQRT_W-1:0]        jump;

  // search registers
  logic signed [DATA_W-1:0] target;
  logic [CNT_W-1:0]         lo;
  logic [CNT_W-1:0]         hi;
  logic [CNT_W-1:0]         idx;
  logic [POS_W-1:0]         pos;

  // square root unit
  logic [RAD_W-1:0]         sq_rad;
  logic [REM_W-1:0]         sq_rem;
  logic [SQRT_W-1:0]        sq_root;
  logic [STEP_W-1:0]        sq_cnt;

  // output register
  logic                     rsp_valid;
  logic [POS_W-1:0]         rsp_pos;

  // table
  logic [DATA_W-1:0]        mem [MEM_DEPTH];
  logic [DATA_W-1:0]        rd_data;
  logic [CNT_W-1:0]         rd_idx;
  logic                     wr_en;

  logic                     cfg_fire;
  logic                     req_fire;
  logic [CNT_W-1:0]         n_cap;
  logic [CNT_W-1:0]         jump_ext;
  logic [CNT_W-1:0]         hi_step;
  logic [CNT_W-1:0]         lim_cur;
  logic [CNT_W-1:0]         lim_step;
  logic [CNT_W-1:0]         lim_start;
  logic [CNT_W-1:0]         idx_inc;
  logic                     below;
  logic                     equal;

  logic [REM_W+1:0]         rem_sh;
  logic [REM_W+1:0]         trial;
  logic [REM_W+1:0]         rem_diff;
  logic                     sq_ge;
  logic [REM_W-1:0]         rem_next;
  logic [SQRT_W-1:0]        root_next;

  // --------------------------------------------------------------------------
  // Handshakes: configuration wins over an item in the same idle cycle so a
  // search never runs with a stale jump step.
  // --------------------------------------------------------------------------
  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid               = rsp_valid;
  assign rsp.data.match_position = rsp_pos;

  // --------------------------------------------------------------------------
  // Search datapath
  // --------------------------------------------------------------------------
  assign n_cap     = cap_count(entries_in_use);
  assign jump_ext  = CNT_W'(jump);
  assign hi_step   = hi + jump_ext;
  assign lim_cur   = (hi < n_cap) ? hi : n_cap;
  assign lim_step  = (hi_step < n_cap) ? hi_step : n_cap;
  assign lim_start = (jump_ext < n_cap) ? jump_ext : n_cap;
  assign idx_inc   = idx + CNT_W'(1);
  assign below     = $signed(rd_data) < target;
  assign equal     = $signed(rd_data) == target;

  // Read address for the next cycle's compare: last entry of the first
  // block at start, last entry of the next block or the block start while
  // jumping, next entry while scanning.
  always_comb begin
    case (state)
      S_IDLE:  rd_idx = lim_start - CNT_W'(1);
      S_JUMP:  rd_idx = below ? (lim_step - CNT_W'(1)) : lo;
      S_SCAN:  rd_idx = idx_inc;
      default: rd_idx = '0;
    endcase
  end

  // Drop writes past the table depth.
  assign wr_en = req_fire && (req.data.opcode == OP_WRITE) &&
                 (int'(req.data.write_index) < TABLE_DEPTH);

  // Table store: one write port, one registered read port. Writes only
  // happen in idle, so a read never races a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req.data.write_index[MAW-1:0]] <= req.data.item_value;
    end
    rd_data <= mem[rd_idx[MAW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Square root: restoring digit recurrence, two radicand bits per cycle.
  // --------------------------------------------------------------------------
  assign rem_sh    = {sq_rem, sq_rad[RAD_W-1 -: 2]};
  assign trial     = {2'b00, sq_root, 2'b01};
  assign sq_ge     = rem_sh >= trial;
  assign rem_diff  = rem_sh - trial;
  assign rem_next  = sq_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
  assign root_next = {sq_root[SQRT_W-2:0], sq_ge};

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_in_use <= '0;
      jump           <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      // drop the result once taken; the final state reloads it on its own
      if (rsp_valid && rsp.ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            entries_in_use <= cfg.data;
            sq_rad         <= {{(RAD_W-CNT_W){1'b0}}, cap_count(cfg.data)};
            sq_rem         <= '0;
            sq_root        <= '0;
            sq_cnt         <= '0;
            state          <= S_SQRT;
          end else if (req_fire && (req.data.opcode == OP_SEARCH)) begin
            target <= req.data.item_value;
            if (n_cap == '0) begin
              // empty table: answer without touching the store
              pos   <= POS_NONE;
              state <= S_FIN;
            end else begin
              lo    <= '0;
              hi    <= jump_ext;
              state <= S_JUMP;
            end
          end
        end

        S_SQRT: begin
          sq_rem  <= rem_next;
          sq_root <= root_next;
          sq_rad  <= {sq_rad[RAD_W-3:0], 2'b00};
          sq_cnt  <= sq_cnt + STEP_W'(1);
          if (sq_cnt == STEP_W'(SQRT_STEPS - 1)) begin
            jump  <= root_next;
            state <= S_IDLE;
          end
        end

        S_JUMP: begin
          // rd_data holds the last entry of the block [lo, hi)
          if (below) begin
            if (hi >= n_cap) begin
              pos   <= POS_NONE;
              state <= S_FIN;
            end else begin
              lo <= hi;
              hi <= hi_step;
            end
          end else begin
            idx   <= lo;
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          // rd_data holds entry idx
          if (equal) begin
            pos   <= POS_W'(idx);
            state <= S_FIN;
          end else if (idx_inc >= lim_cur) begin
            pos   <= POS_NONE;
            state <= S_FIN;
          end else begin
            idx <= idx_inc;
          end
        end

        S_FIN: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_pos   <= pos;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/jss_checker.sv
// ----------------------------------------------------------------------------
// jss_checker
// Port-level checks for the jump search table, bound to the top level.
// ----------------------------------------------------------------------------
module jss_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      req_valid,
  input logic                      req_ready,
  input jss_pkg::op_t              req_opcode,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [jss_pkg::POS_W-1:0] rsp_pos
);

  import jss_pkg::*;

  // a waiting result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos))
    else $error("result changed or vanished while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // a write item never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_opcode == OP_WRITE) && !rsp_valid |=> !rsp_valid)
    else $error("write item produced a result");

  // an accepted search keeps the block busy for the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_opcode == OP_SEARCH) |=> !req_ready)
    else $error("item taken while a search is in flight");

  // configuration and an item are never taken together
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !(req_valid && req_ready))
    else $error("configuration write and item taken in the same cycle");

endmodule

bind jump_search_sorted_table jss_checker u_jss_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_opcode (req.data.opcode),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_pos    (rsp.data.match_position)
);

FILE: dv/tb_jump_search_sorted_table.sv
// ----------------------------------------------------------------------------
// tb_jump_search_sorted_table
// Self-checking bench for the jump search table block: fills the table in
// order, then runs directed and random searches under several entry counts
// and idle patterns. Each search result is checked against a jump search
// worked out here on a local copy of the table.
// ----------------------------------------------------------------------------
module tb_jump_search_sorted_table;

  timeunit 1ns;
  timeprecision 1ps;

  import jss_pkg::*;

  localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SEARCH_LATENCY = 70;
  localparam int REPORT_LIMIT   = 10;
  localparam int STALL_CYCLES   = 300;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst;

  jss_chan_if #(.T(cfg_word_t)) cfg_ch ();
  jss_chan_if #(.T(req_item_t)) req_ch ();
  jss_chan_if #(.T(rsp_item_t)) rsp_ch ();

  // The configuration channel carries the single register, entries_in_use.
  jump_search_sorted_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Local copy of the table and the count register
  logic signed [DATA_W-1:0] table_copy [TABLE_DEPTH];
  cfg_word_t                entries_cfg;

  // Positions that accepted searches should return, oldest first
  logic signed [POS_W-1:0]  expected_positions [$];

  int  mismatch_count;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  logic recv_hold;
  event hold_go;

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("tb_jump_search_sorted_table: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Jump search on the local copy: step is the floor square root of the
  // covered count; hop while the block's last entry is below the target,
  // then scan the block for the first equal entry.
  // --------------------------------------------------------------------------
  function automatic int covered_entries();
    return (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg);
  endfunction

  function automatic logic signed [POS_W-1:0] jump_search_position(
    input logic signed [DATA_W-1:0] target
  );
    int n;
    int step;
    int lo;
    int hi;
    int lim;
    int i;
    n = covered_entries();
    // Empty table: no entry is read
    if (n == 0) return POS_NONE;
    step = 0;
    while ((step + 1) * (step + 1) <= n) step++;
    lo = 0;
    hi = step;
    forever begin
      lim = (hi < n) ? hi : n;
      if (!(table_copy[lim-1] < target)) break;
      lo = hi;
      hi += step;
      if (lo >= n) return POS_NONE;
    end
    lim = (hi < n) ? hi : n;
    for (i = lo; i < lim; i++) begin
      if (table_copy[i] == target) return POS_W'(i);
    end
    return POS_NONE;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: take results, check each against the oldest expectation,
  // and drive ready with random idling plus the long hold-off.
  // --------------------------------------------------------------------------
  initial begin : result_checker
    logic signed [POS_W-1:0] want;
    logic signed [POS_W-1:0] got;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data.match_position;
        if (expected_positions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result, match_position %0d", $realtime, got);
        end else begin
          want = expected_positions.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: match_position mismatch, expected %0d, got %0d",
                       $realtime, want, got);
          end
        end
      end
      rsp_ch.ready <= !rst && !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Hold off the result side for a long stretch on request
  initial begin : result_hold
    recv_hold = 1'b0;
    forever begin
      @(hold_go);
      recv_hold <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers. All of them are entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Offer one item and hold it until taken. Valid stays high on return so
  // back-to-back items see no gap; the next call replaces it or stop_items drops it.
  task automatic send_item(
    input op_t                      op,
    input logic [IDX_W-1:0]         idx,
    input logic signed [DATA_W-1:0] value
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{opcode: op, write_index: idx, item_value: value};
    do @(posedge clk); while (!req_ch.ready);
    // Item taken at this edge: advance the local copy
    if (op == OP_WRITE) begin
      table_copy[idx] = value;
    end else begin
      expected_positions.push_back(jump_search_position(value));
    end
  endtask

  task automatic stop_items();
    req_ch.valid <= 1'b0;
  endtask

  // Wait until every search has answered, then let a search's worth of
  // cycles pass so a trailing write has surely settled too.
  task automatic wait_idle();
    stop_items();
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SEARCH_LATENCY) @(posedge clk);
  endtask

  // Write entries_in_use; call only when the block is idle.
  task automatic write_count(input cfg_word_t count);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= count;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    entries_cfg = count;
  endtask

  // Search target: mostly entries inside the covered range, plus near
  // misses, the word extremes and fully random words.
  function automatic logic signed [DATA_W-1:0] pick_target();
    int n;
    int k;
    int sel;
    n   = covered_entries();
    k   = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, TABLE_DEPTH - 1);
    sel = $urandom_range(0, 99);
    if (sel < 45) return table_copy[k];
    if (sel < 65) return table_copy[k] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
    if (sel < 72) return WORD_MIN;
    if (sel < 79) return WORD_MAX;
    if (sel < 87) return (n > 0) ? table_copy[n-1] + 32'sd1 : table_copy[0];
    return $urandom;
  endfunction

  // Entry count: the full table first, then the extremes and block-size edges
  // now and then, otherwise anything in range.
  function automatic cfg_word_t pick_count(input int seg);
    cfg_word_t edges [12] = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd15, 11'd16,
                              11'd17, 11'd1023, 11'd1024, 11'd1025, 11'd2047};
    if (seg == 0) return cfg_word_t'(TABLE_DEPTH);
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 11)];
    return cfg_word_t'($urandom_range(1, TABLE_DEPTH));
  endfunction

  // Write one entry; mostly keep the order by picking a value between the
  // neighbors, sometimes drop in any word and break it.
  task automatic write_random_entry();
    int     i;
    longint lo;
    longint hi;
    longint off;
    longint v;
    i = $urandom_range(0, TABLE_DEPTH - 1);
    if ($urandom_range(0, 9) == 0) begin
      send_item(OP_WRITE, IDX_W'(i), $urandom);
    end else begin
      lo = (i > 0) ? longint'(table_copy[i-1]) : longint'(WORD_MIN);
      hi = (i < TABLE_DEPTH - 1) ? longint'(table_copy[i+1]) : longint'(WORD_MAX);
      if (hi < lo) begin
        v = lo;
      end else begin
        off = {32'd0, $urandom};
        v   = lo + off % (hi - lo + 1);
      end
      send_item(OP_WRITE, IDX_W'(i), DATA_W'(v));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty table: the reset count is zero, so searches answer -1 before any
  // entry exists; then write zero explicitly and ask again.
  task automatic test_empty_after_reset();
    send_item(OP_SEARCH, '0, 32'sd0);
    send_item(OP_SEARCH, '1, WORD_MAX);
    wait_idle();
    write_count('0);
    send_item(OP_SEARCH, IDX_W'($urandom), WORD_MIN);
    wait_idle();
  endtask

  // Fill every entry in ascending order from the lowest to the highest
  // word, with some duplicates, so no search ever reads an unwritten entry.
  task automatic fill_sorted_table();
    longint v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        v = longint'(WORD_MIN);
      end else if (i == TABLE_DEPTH - 1) begin
        v = longint'(WORD_MAX);
      end else begin
        v = longint'(table_copy[i-1]);
        if ($urandom_range(0, 7) != 0) v += $urandom_range(1, 8_000_000);
        if (v > longint'(WORD_MAX)) v = longint'(WORD_MAX);
      end
      send_item(OP_WRITE, IDX_W'(i), DATA_W'(v));
    end
    wait_idle();
  endtask

  task automatic test_directed_cases();
    int dup;
    logic signed [DATA_W-1:0] saved;
    // Full table: first, last, middle, a miss between entries
    write_count(cfg_word_t'(TABLE_DEPTH));
    send_item(OP_SEARCH, '0, table_copy[0]);
    send_item(OP_SEARCH, '1, table_copy[TABLE_DEPTH-1]);
    send_item(OP_SEARCH, '0, table_copy[512]);
    send_item(OP_SEARCH, '1, table_copy[511] + 32'sd1);
    send_item(OP_SEARCH, '0, WORD_MIN + 32'sd1);
    // Duplicate entries: the first of the pair within the block
    dup = 0;
    for (int i = 1; i < TABLE_DEPTH && dup == 0; i++)
      if (table_copy[i] == table_copy[i-1]) dup = i;
    send_item(OP_SEARCH, '1, table_copy[dup]);
    wait_idle();
    // Single entry: a hit and a target past the covered range
    write_count(11'd1);
    send_item(OP_SEARCH, '0, table_copy[0]);
    send_item(OP_SEARCH, '1, table_copy[1]);
    wait_idle();
    // Count too large: treated as the full table
    write_count(11'd2047);
    send_item(OP_SEARCH, '0, table_copy[TABLE_DEPTH-1]);
    send_item(OP_SEARCH, '1, table_copy[1000]);
    send_item(OP_SEARCH, '0, WORD_MAX - 32'sd1);
    wait_idle();
    // Partial last block
    write_count(11'd17);
    send_item(OP_SEARCH, '0, table_copy[16]);
    send_item(OP_SEARCH, '1, table_copy[17]);
    send_item(OP_SEARCH, '0, WORD_MAX);
    wait_idle();
    // Unsorted table: plant a large word early, search past it, restore
    write_count(11'd16);
    saved = table_copy[3];
    send_item(OP_WRITE, IDX_W'(3), WORD_MAX);
    send_item(OP_SEARCH, '1, table_copy[6]);
    send_item(OP_SEARCH, '0, WORD_MAX);
    send_item(OP_WRITE, IDX_W'(3), saved);
    send_item(OP_SEARCH, '1, table_copy[6]);
    wait_idle();
  endtask

  // Random writes and searches over a run of entry counts
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      write_count(pick_count(seg));
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          write_random_entry();
        end else begin
          send_item(OP_SEARCH, IDX_W'($urandom), pick_target());
        end
      end
    end
    wait_idle();
  endtask

  // Hold the result side off for a long stretch while searches keep
  // coming, so the block fills up and stalls its input.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_count(cfg_word_t'(TABLE_DEPTH));
    -> hold_go;
    for (int k = 0; k < 12; k++)
      send_item(OP_SEARCH, IDX_W'($urandom), pick_target());
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    entries_cfg    = '0;
    mismatch_count = 0;
    send_idle_pct  = 18;
    recv_idle_pct  = 65;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_after_reset();
    fill_sorted_table();
    test_directed_cases();
    test_random_traffic(18, 65);
    test_random_traffic(65, 18);
    test_random_traffic(0, 0);
    test_output_stall();

    // wait_idle already let the tail latency pass
    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("tb_jump_search_sorted_table: done, clean");
    end else begin
      $display("tb_jump_search_sorted_table: done, errors");
    end
    $finish;
  end

endmodule
